/* rtl/core/byte_budget_lru_cache_core_macros.svh */
`ifndef BYTE_BUDGET_LRU_CACHE_CORE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define BBLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define BBLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bblc_pkg.sv */
`timescale 1ns / 1ps
package bblc_pkg;

  localparam int ENTRIES      = 16;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int KEY_BITS     = 32;
  localparam int SIZE_BITS    = 32;
  localparam int PAYLOAD_BITS = 32;

  typedef enum logic [1:0] {
    MODE_GET    = 2'd0,
    MODE_PUT    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [SIZE_BITS-1:0]    size;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_ACT,
    ST_PUT_SEL,
    ST_PUT_LRU,
    ST_EV_CHK,
    ST_EV_DROP,
    ST_PUT_WR,
    ST_RESULT
  } state_t;

endpackage

/* rtl/core/bblc_req_if.sv */
`timescale 1ns / 1ps
interface bblc_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic [bblc_pkg::KEY_BITS-1:0]     key;
  logic [bblc_pkg::SIZE_BITS-1:0]    size_bytes;
  logic [bblc_pkg::PAYLOAD_BITS-1:0] payload;

  modport source (output valid, mode, key, size_bytes, payload, input ready);
  modport sink (input valid, mode, key, size_bytes, payload, output ready);
endinterface

/* rtl/core/bblc_rsp_if.sv */
`timescale 1ns / 1ps
interface bblc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic [bblc_pkg::PAYLOAD_BITS-1:0] payload_out;
  logic [bblc_pkg::SIZE_BITS-1:0]    used_total;

  modport source (output valid, ok, payload_out, used_total, input ready);
  modport sink (input valid, ok, payload_out, used_total, output ready);
endinterface

/* rtl/core/byte_budget_lru_cache_core.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Handshake        | Carries
// in_req   | in        | valid / ready    | mode, key, size_bytes, payload
// out_rsp  | out       | valid / ready    | ok, payload_out, used_total
// cfg      | in        | cfg_we           | cfg_wdata: byte budget
//
// A get or remove runs dispatch, key search, action and result; the key search reads one
// slot a cycle from the slot memory. A put adds slot select, an LRU drop with a full table,
// an eviction check with a drop for every entry evicted, and the write. After a budget write
// the next item first runs the eviction check and its drops. A clear skips the key search.
// in_req.ready is high only in idle; the result register lets the next item enter while a
// result waits on out_rsp. rst_n is synchronous, active low; it empties table and budget.
`include "byte_budget_lru_cache_core_macros.svh"
module byte_budget_lru_cache_core (
  input  logic                           clk,
  input  logic                           rst_n,
  bblc_req_if.sink                       in_req,
  bblc_rsp_if.source                     out_rsp,
  input  logic                           cfg_we,
  input  logic [bblc_pkg::SIZE_BITS-1:0] cfg_wdata
);

  localparam int N  = bblc_pkg::ENTRIES;
  localparam int IW = bblc_pkg::IDX_W;
  localparam int CW = bblc_pkg::CNT_W;
  localparam int SW = bblc_pkg::SIZE_BITS;
  localparam int PW = bblc_pkg::PAYLOAD_BITS;
  localparam int KW = bblc_pkg::KEY_BITS;

  bblc_pkg::state_t state_r, state_nxt;
  bblc_pkg::state_t ret_r, ret_nxt;

  logic [1:0]    mode_r, mode_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [PW-1:0] pl_r, pl_nxt;

  logic [SW-1:0] cap_r, cap_nxt;
  logic          recheck_r, recheck_nxt;
  logic [SW-1:0] used_r, used_nxt;
  logic [SW-1:0] lim_r, lim_nxt;

  logic [N-1:0]  valid_r, valid_nxt;
  logic [IW-1:0] age_r [N];
  logic [IW-1:0] age_nxt [N];

  logic [CW-1:0] scan_r, scan_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [SW-1:0] hit_size_r, hit_size_nxt;
  logic [PW-1:0] hit_pl_r, hit_pl_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;

  logic          ok_r, ok_nxt;
  logic [PW-1:0] pout_r, pout_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [PW-1:0] out_pl_r, out_pl_nxt;
  logic [SW-1:0] out_used_r, out_used_nxt;

  // Slot memory: one read and one write port, registered read.
  bblc_pkg::slot_t mem [N];
  bblc_pkg::slot_t rd_data_r;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;

  // Recency search: the least-recent valid slot has rank (valid count - 1).
  logic [CW-1:0] n_valid;
  logic [IW-1:0] lru_idx;
  logic [IW-1:0] free_idx;
  logic          free_any;
  logic          match;
  logic          scan_last;
  logic          in_acc;

  always_comb begin
    n_valid = '0;
    for (int i = 0; i < N; i++) begin
      n_valid = n_valid + CW'(valid_r[i]);
    end
  end

  always_comb begin
    lru_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_r[i] && ({1'b0, age_r[i]} == CW'(n_valid - CW'(1)))) begin
        lru_idx = IW'(i);
      end
    end
  end

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign in_acc    = in_req.valid && in_req.ready;
  assign match     = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data_r.key == key_r);
  assign scan_last = cmp_vld_r && (cmp_idx_r == IW'(N - 1));

  assign in_req.ready        = (state_r == bblc_pkg::ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_ok_r;
  assign out_rsp.payload_out = out_pl_r;
  assign out_rsp.used_total  = out_used_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bblc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = recheck_r ? bblc_pkg::ST_EV_CHK : bblc_pkg::ST_DISPATCH;
        end
      end
      bblc_pkg::ST_DISPATCH: begin
        state_nxt = (mode_r == bblc_pkg::MODE_CLEAR) ? bblc_pkg::ST_RESULT
                                                     : bblc_pkg::ST_SCAN;
      end
      bblc_pkg::ST_SCAN: begin
        if (match || scan_last) begin
          state_nxt = bblc_pkg::ST_ACT;
        end
      end
      bblc_pkg::ST_ACT: begin
        if ((mode_r == bblc_pkg::MODE_PUT) && (size_r <= cap_r)) begin
          state_nxt = bblc_pkg::ST_PUT_SEL;
        end else begin
          state_nxt = bblc_pkg::ST_RESULT;
        end
      end
      bblc_pkg::ST_PUT_SEL: begin
        state_nxt = free_any ? bblc_pkg::ST_EV_CHK : bblc_pkg::ST_PUT_LRU;
      end
      bblc_pkg::ST_PUT_LRU: state_nxt = bblc_pkg::ST_EV_CHK;
      bblc_pkg::ST_EV_CHK: begin
        state_nxt = ((used_r > lim_r) && (n_valid != '0)) ? bblc_pkg::ST_EV_DROP : ret_r;
      end
      bblc_pkg::ST_EV_DROP: state_nxt = bblc_pkg::ST_EV_CHK;
      bblc_pkg::ST_PUT_WR:  state_nxt = bblc_pkg::ST_RESULT;
      bblc_pkg::ST_RESULT: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = bblc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bblc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and table updates.
  always_comb begin
    logic          do_drop;
    logic [IW-1:0] d_idx;
    logic [SW-1:0] d_size;
    logic          do_touch;
    logic          do_ins;

    do_drop  = 1'b0;
    d_idx    = '0;
    d_size   = '0;
    do_touch = 1'b0;
    do_ins   = 1'b0;

    mode_nxt     = mode_r;
    key_nxt      = key_r;
    size_nxt     = size_r;
    pl_nxt       = pl_r;
    cap_nxt      = cap_r;
    recheck_nxt  = recheck_r;
    used_nxt     = used_r;
    lim_nxt      = lim_r;
    ret_nxt      = ret_r;
    valid_nxt    = valid_r;
    scan_nxt     = scan_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_size_nxt = hit_size_r;
    hit_pl_nxt   = hit_pl_r;
    slot_nxt     = slot_r;
    ev_idx_nxt   = ev_idx_r;
    ok_nxt       = ok_r;
    pout_nxt     = pout_r;
    rd_addr      = lru_idx;
    mem_we       = 1'b0;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_ok_nxt    = out_ok_r;
    out_pl_nxt    = out_pl_r;
    out_used_nxt  = out_used_r;

    if (cfg_we) begin
      cap_nxt     = cfg_wdata;
      recheck_nxt = 1'b1;
    end

    case (state_r)
      bblc_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_req.mode;
          key_nxt  = in_req.key;
          size_nxt = in_req.size_bytes;
          pl_nxt   = in_req.payload;
          lim_nxt  = cap_r;
          ret_nxt  = bblc_pkg::ST_DISPATCH;
        end
      end
      bblc_pkg::ST_DISPATCH: begin
        recheck_nxt = 1'b0;
        ok_nxt      = 1'b0;
        pout_nxt    = '0;
        scan_nxt    = '0;
        cmp_vld_nxt = 1'b0;
        hit_nxt     = 1'b0;
        if (mode_r == bblc_pkg::MODE_CLEAR) begin
          valid_nxt = '0;
          used_nxt  = '0;
        end
      end
      bblc_pkg::ST_SCAN: begin
        rd_addr     = scan_r[IW-1:0];
        cmp_vld_nxt = (scan_r < CW'(N));
        cmp_idx_nxt = scan_r[IW-1:0];
        scan_nxt    = scan_r + CW'(1);
        if (match) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = cmp_idx_r;
          hit_size_nxt = rd_data_r.size;
          hit_pl_nxt   = rd_data_r.payload;
        end
      end
      bblc_pkg::ST_ACT: begin
        if (hit_r) begin
          case (mode_r)
            bblc_pkg::MODE_GET: begin
              do_touch = 1'b1;
              ok_nxt   = 1'b1;
              pout_nxt = hit_pl_r;
            end
            bblc_pkg::MODE_REMOVE: begin
              do_drop = 1'b1;
              ok_nxt  = 1'b1;
            end
            bblc_pkg::MODE_PUT: do_drop = 1'b1;
            default: ;
          endcase
        end
        d_idx  = hit_idx_r;
        d_size = hit_size_r;
      end
      bblc_pkg::ST_PUT_SEL: begin
        lim_nxt  = cap_r - size_r;
        ret_nxt  = bblc_pkg::ST_PUT_WR;
        slot_nxt = free_any ? free_idx : lru_idx;
      end
      bblc_pkg::ST_PUT_LRU: begin
        do_drop = 1'b1;
        d_idx   = slot_r;
        d_size  = rd_data_r.size;
      end
      bblc_pkg::ST_EV_CHK: begin
        ev_idx_nxt = lru_idx;
      end
      bblc_pkg::ST_EV_DROP: begin
        do_drop     = 1'b1;
        d_idx       = ev_idx_r;
        d_size      = rd_data_r.size;
        recheck_nxt = 1'b0;
      end
      bblc_pkg::ST_PUT_WR: begin
        do_ins   = 1'b1;
        mem_we   = 1'b1;
        used_nxt = used_r + size_r;
        ok_nxt   = 1'b1;
      end
      bblc_pkg::ST_RESULT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_pl_nxt    = pout_r;
          out_used_nxt  = used_r;
        end
      end
      default: ;
    endcase

    for (int i = 0; i < N; i++) begin
      age_nxt[i] = age_r[i];
      if (do_drop && valid_r[i] && (IW'(i) != d_idx) && (age_r[i] > age_r[d_idx])) begin
        age_nxt[i] = age_r[i] - IW'(1);
      end
      if (do_touch && valid_r[i] && (IW'(i) != hit_idx_r) &&
          (age_r[i] < age_r[hit_idx_r])) begin
        age_nxt[i] = age_r[i] + IW'(1);
      end
      if (do_ins && valid_r[i]) begin
        age_nxt[i] = age_r[i] + IW'(1);
      end
    end
    if (do_drop) begin
      valid_nxt[d_idx] = 1'b0;
      used_nxt         = used_r - d_size;
    end
    if (do_touch) begin
      age_nxt[hit_idx_r] = '0;
    end
    if (do_ins) begin
      valid_nxt[slot_r] = 1'b1;
      age_nxt[slot_r]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= '{key: key_r, size: size_r, payload: pl_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bblc_pkg::ST_IDLE;
      ret_r       <= bblc_pkg::ST_DISPATCH;
      cap_r       <= '0;
      recheck_r   <= 1'b0;
      used_r      <= '0;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cap_r       <= cap_nxt;
      recheck_r   <= recheck_nxt;
      used_r      <= used_nxt;
      valid_r     <= valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    size_r     <= size_nxt;
    pl_r       <= pl_nxt;
    lim_r      <= lim_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_size_r <= hit_size_nxt;
    hit_pl_r   <= hit_pl_nxt;
    slot_r     <= slot_nxt;
    ev_idx_r   <= ev_idx_nxt;
    ok_r       <= ok_nxt;
    pout_r     <= pout_nxt;
    out_ok_r   <= out_ok_nxt;
    out_pl_r   <= out_pl_nxt;
    out_used_r <= out_used_nxt;
    for (int i = 0; i < N; i++) begin
      age_r[i] <= age_nxt[i];
    end
  end

  // A stored put never leaves the bytes in use above the budget.
  `BBLC_ASSERT_NEXT(a_put_fits, state_r == bblc_pkg::ST_PUT_WR,
    used_r <= cap_r, "put over budget")
  // The slot chosen for a new record is free when it is written.
  `BBLC_ASSERT_IMP(a_put_slot_free, state_r == bblc_pkg::ST_PUT_WR,
    !valid_r[slot_r], "put slot busy")
  // Eviction only ever drops a live entry.
  `BBLC_ASSERT_IMP(a_evict_live, state_r == bblc_pkg::ST_EV_DROP,
    valid_r[ev_idx_r], "evict dead slot")
  // A clear empties the table.
  `BBLC_ASSERT_NEXT(a_clear_empty,
    state_r == bblc_pkg::ST_DISPATCH && mode_r == bblc_pkg::MODE_CLEAR,
    valid_r == '0 && used_r == '0, "clear left entries")

endmodule
